// File: hdl/tvpt_pkg.sv
// Package for the timed valve position tracker.
// Holds the command codes, the sequencer states and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tvpt_pkg;

  localparam int POS_W   = 14;          // position field width
  localparam int CMD_W   = 2;           // command field width
  localparam int CFG_W   = 16;          // stroke register width
  localparam int TT_W    = 16;          // travel_time output width
  localparam int QUO_W   = 16;          // quotient bits per division
  localparam int CNT_W   = 4;           // step counter, counts to QUO_W-1

  localparam logic [POS_W-1:0] POS_FULL    = 14'd10000;
  localparam logic [CFG_W-1:0] STROKE_RST  = 16'd10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_HFIX,
    ST_MSET,
    ST_MFIX,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// File: hdl/timed_valve_position_tracker_unit.sv
// Top level of the timed valve position tracker.
// Bit-serial multiply and restoring divide sequencer; depends on tvpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Tracks an open-loop valve position (0 fully open, 10000 fully closed) from
// move, stop and tick requests and returns one result per request. A shared
// unit multiplies one bit per cycle and divides one quotient bit per cycle;
// a move from rest runs a travel plan through it, a stop during travel runs
// a halt, and a move during travel runs a halt followed by a new travel plan.
// A new request is taken once the previous one is finished, even while its
// result still waits in the output register.
module timed_valve_position_tracker_unit
  import tvpt_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [POS_W-1:0]  in_target,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       out_position,
  output logic                   out_moving,
  output logic                   out_opening,
  output logic                   out_done_res,
  output logic [TT_W-1:0]        out_travel_time,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int BW = (TW > CFG_W) ? TW : CFG_W;   // multiplicand / divisor width
  localparam int PW = POS_W + BW;                  // product width
  localparam logic [TW-1:0] TIME_MAX   = {TW{1'b1}};
  localparam logic [BW-1:0] TIME_MAX_B = BW'(TIME_MAX);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(POS_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  tgt_r, tgt_nxt;
  logic              done_r, done_nxt;
  logic [POS_W-1:0]  settled_r, settled_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [POS_W-1:0]  goal_r, goal_nxt;
  logic [TW-1:0]     travel_r, travel_nxt;
  logic [TW-1:0]     elapsed_r, elapsed_nxt;
  logic              motion_r, motion_nxt;
  logic              phase_r, phase_nxt;     // 0 halt, 1 travel planning
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  mul_a_r, mul_a_nxt;
  logic [BW-1:0]     mul_b_r, mul_b_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [BW-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [BW-1:0]     div_r, div_nxt;
  logic [CFG_W-1:0]  stroke_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_mov_r, out_mov_nxt;
  logic              out_open_r, out_open_nxt;
  logic              out_done_r, out_done_nxt;
  logic [TT_W-1:0]   out_tt_r, out_tt_nxt;

  logic              down;
  logic [TW-1:0]     e_cap;
  logic [TW-1:0]     e_inc;
  logic [PW-1:0]     adj;
  logic [PW-1:0]     sum;
  logic [BW:0]       shifted;
  logic [BW:0]       diff;
  logic              ge;
  logic [BW-1:0]     t_ext;
  logic [BW-1:0]     t_sat;
  logic [POS_W-1:0]  span;

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_position    = out_pos_r;
  assign out_moving      = out_mov_r;
  assign out_opening     = out_open_r;
  assign out_done_res    = out_done_r;
  assign out_travel_time = out_tt_r;

  // datapath helpers
  assign down    = (goal_r < start_r);
  assign e_cap   = (elapsed_r > travel_r) ? travel_r : elapsed_r;
  assign e_inc   = (elapsed_r != TIME_MAX) ? elapsed_r + TW'(1) : elapsed_r;
  assign adj     = (!phase_r && down) ? (PW'(travel_r) - PW'(1)) : '0;
  assign sum     = prod_r + adj;
  assign shifted = {rem_r, quo_r[QUO_W-1]};
  assign ge      = (shifted >= {1'b0, div_r});
  assign diff    = shifted - {1'b0, div_r};
  assign t_ext   = BW'(quo_r);
  assign t_sat   = (t_ext > TIME_MAX_B) ? TIME_MAX_B : t_ext;
  assign span    = (tgt_r > settled_r) ? (tgt_r - settled_r) : (settled_r - tgt_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    done_nxt      = done_r;
    settled_nxt   = settled_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    travel_nxt    = travel_r;
    elapsed_nxt   = elapsed_r;
    motion_nxt    = motion_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_mov_nxt   = out_mov_r;
    out_open_nxt  = out_open_r;
    out_done_nxt  = out_done_r;
    out_tt_nxt    = out_tt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          tgt_nxt   = (in_target > POS_FULL) ? POS_FULL : in_target;
          done_nxt  = 1'b0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_FIN;
        unique case (cmd_r) inside
          CMD_MOVE, CMD_STOP: begin
            if (motion_r) begin
              // halt: scale the distance covered by elapsed / travel
              mul_a_nxt = down ? (start_r - goal_r) : (goal_r - start_r);
              mul_b_nxt = BW'(e_cap);
              prod_nxt  = '0;
              cnt_nxt   = '0;
              phase_nxt = 1'b0;
              state_nxt = ST_MUL;
            end else if (cmd_r == CMD_MOVE) begin
              state_nxt = ST_MSET;
            end
          end
          CMD_TICK: begin
            if (motion_r) begin
              if (e_inc >= travel_r) begin
                settled_nxt = goal_r;
                motion_nxt  = 1'b0;
                travel_nxt  = '0;
                elapsed_nxt = '0;
                done_nxt    = 1'b1;
              end else begin
                elapsed_nxt = e_inc;
              end
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_MUL: begin
        // one multiplier bit per cycle, most significant first
        prod_nxt  = {prod_r[PW-2:0], 1'b0} + (mul_a_r[POS_W-1] ? PW'(mul_b_r) : '0);
        mul_a_nxt = {mul_a_r[POS_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // high part is already below the divisor, so sixteen steps suffice
        rem_nxt   = BW'(sum[PW-1:QUO_W]);
        quo_nxt   = sum[QUO_W-1:0];
        div_nxt   = phase_r ? BW'(POS_FULL) : BW'(travel_r);
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        rem_nxt = ge ? diff[BW-1:0] : shifted[BW-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = phase_r ? ST_MFIX : ST_HFIX;
        end
      end

      ST_HFIX: begin
        settled_nxt = down ? (start_r - quo_r[POS_W-1:0]) : (start_r + quo_r[POS_W-1:0]);
        motion_nxt  = 1'b0;
        travel_nxt  = '0;
        elapsed_nxt = '0;
        done_nxt    = 1'b1;
        state_nxt   = (cmd_r == CMD_MOVE) ? ST_MSET : ST_FIN;
      end

      ST_MSET: begin
        if (tgt_r != settled_r) begin
          mul_a_nxt = span;
          mul_b_nxt = BW'(stroke_r);
          prod_nxt  = '0;
          cnt_nxt   = '0;
          phase_nxt = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_MFIX: begin
        if (t_sat == '0) begin
          settled_nxt = tgt_r;
          done_nxt    = 1'b1;
        end else begin
          start_nxt   = settled_r;
          goal_nxt    = tgt_r;
          travel_nxt  = t_sat[TW-1:0];
          elapsed_nxt = '0;
          motion_nxt  = 1'b1;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = settled_r;
          out_mov_nxt   = motion_r;
          out_open_nxt  = motion_r && down;
          out_done_nxt  = done_r;
          out_tt_nxt    = motion_r ? TT_W'(travel_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      settled_r   <= '0;
      start_r     <= '0;
      goal_r      <= '0;
      travel_r    <= '0;
      elapsed_r   <= '0;
      motion_r    <= 1'b0;
      out_valid_r <= 1'b0;
      stroke_r    <= STROKE_RST;
    end else begin
      state_r     <= state_nxt;
      settled_r   <= settled_nxt;
      start_r     <= start_nxt;
      goal_r      <= goal_nxt;
      travel_r    <= travel_nxt;
      elapsed_r   <= elapsed_nxt;
      motion_r    <= motion_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        stroke_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tgt_r      <= tgt_nxt;
    done_r     <= done_nxt;
    phase_r    <= phase_nxt;
    cnt_r      <= cnt_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_r      <= div_nxt;
    out_pos_r  <= out_pos_nxt;
    out_mov_r  <= out_mov_nxt;
    out_open_r <= out_open_nxt;
    out_done_r <= out_done_nxt;
    out_tt_r   <= out_tt_nxt;
  end

endmodule

`default_nettype wire

// File: test/tvpt_checker.sv
// Result checker for the timed valve position tracker testbench.
// Watches the request, result and stroke register channels, predicts each result
// and compares it field by field; depends on tvpt_pkg.
`timescale 1ns / 1ps

module tvpt_result_checker
  import tvpt_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [POS_W-1:0]  in_target,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [POS_W-1:0]  out_position,
  input  logic              out_moving,
  input  logic              out_opening,
  input  logic              out_done_res,
  input  logic [TT_W-1:0]   out_travel_time,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                mismatches,
  output int                pending_results
);

  localparam longint unsigned TIME_MAX = (64'd1 << TIME_WIDTH) - 1;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             moving;
    logic             opening;
    logic             done_res;
    logic [TT_W-1:0]  travel_time;
  } valve_result_t;

  // Tracked valve state and the stroke register copy
  logic [CFG_W-1:0]      stroke;
  logic [POS_W-1:0]      settled_pos;
  logic [POS_W-1:0]      origin_pos;
  logic [POS_W-1:0]      goal_pos;
  logic [TIME_WIDTH-1:0] travel_len;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  in_motion;

  valve_result_t predicted_results[$];

  task automatic log_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Fix the position of a running travel by interpolation, then go idle.
  function automatic void halt_travel();
    longint unsigned e;
    longint unsigned span;
    longint unsigned step;
    if (!in_motion) return;
    e = elapsed;
    if (travel_len == 0 || e > travel_len) e = travel_len;
    if (travel_len == 0) begin
      settled_pos = goal_pos;
    end else if (goal_pos >= origin_pos) begin
      span = goal_pos - origin_pos;
      step = (span * e) / travel_len;
      settled_pos = POS_W'(origin_pos + step);
    end else begin
      // round the step up when opening, so the position never overshoots
      span = origin_pos - goal_pos;
      step = (span * e + travel_len - 1) / travel_len;
      settled_pos = POS_W'(origin_pos - step);
    end
    in_motion = 1'b0;
    travel_len = '0;
    elapsed = '0;
  endfunction

  function automatic valve_result_t valve_step(input cmd_t cmd, input logic [POS_W-1:0] raw);
    valve_result_t   r;
    logic            done;
    longint unsigned tgt;
    longint unsigned span;
    longint unsigned t;
    done = 1'b0;
    tgt = (raw > POS_FULL) ? POS_FULL : raw;
    case (cmd)
      CMD_MOVE: begin
        if (in_motion) begin
          halt_travel();
          done = 1'b1;
        end
        if (tgt != settled_pos) begin
          span = (tgt > settled_pos) ? tgt - settled_pos : settled_pos - tgt;
          t = (span * stroke) / POS_FULL;
          if (t > TIME_MAX) t = TIME_MAX;
          if (t == 0) begin
            settled_pos = POS_W'(tgt);
            done = 1'b1;
          end else begin
            origin_pos = settled_pos;
            goal_pos = POS_W'(tgt);
            travel_len = TIME_WIDTH'(t);
            elapsed = '0;
            in_motion = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (in_motion) begin
          halt_travel();
          done = 1'b1;
        end
      end
      CMD_TICK: begin
        if (in_motion) begin
          if (elapsed < TIME_MAX) elapsed++;
          if (elapsed >= travel_len) begin
            settled_pos = goal_pos;
            in_motion = 1'b0;
            travel_len = '0;
            elapsed = '0;
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.position    = settled_pos;
    r.moving      = in_motion;
    r.opening     = in_motion && (goal_pos < origin_pos);
    r.done_res    = done;
    r.travel_time = in_motion ? TT_W'(travel_len) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    valve_result_t want;
    if (!rst_n) begin
      stroke      = STROKE_RST;
      settled_pos = '0;
      origin_pos  = '0;
      goal_pos    = '0;
      travel_len  = '0;
      elapsed     = '0;
      in_motion   = 1'b0;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) stroke = cfg_data;
      if (in_valid && in_ready)
        predicted_results.push_back(valve_step(cmd_t'(in_cmd), in_target));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          log_mismatch($sformatf("result with no request pending, position %0d",
                                 out_position));
        end else begin
          want = predicted_results.pop_front();
          if (out_position !== want.position)
            log_mismatch($sformatf("position got %0d expected %0d",
                                   out_position, want.position));
          if (out_moving !== want.moving)
            log_mismatch($sformatf("moving got %0b expected %0b", out_moving, want.moving));
          if (out_opening !== want.opening)
            log_mismatch($sformatf("opening got %0b expected %0b",
                                   out_opening, want.opening));
          if (out_done_res !== want.done_res)
            log_mismatch($sformatf("done_res got %0b expected %0b",
                                   out_done_res, want.done_res));
          if (out_travel_time !== want.travel_time)
            log_mismatch($sformatf("travel_time got %0d expected %0d",
                                   out_travel_time, want.travel_time));
        end
      end
    end
    pending_results = predicted_results.size();
  end

endmodule

// File: test/tb_top.sv
// Top of the timed valve position tracker testbench: clock, reset, requests,
// stroke writes and the verdict. Depends on tvpt_pkg, the tracker and tvpt_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import tvpt_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 128;
  localparam int MAX_TICKS   = 120;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_NONE;
  logic [POS_W-1:0] in_target = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [POS_W-1:0] out_position;
  logic             out_moving;
  logic             out_opening;
  logic             out_done_res;
  logic [TT_W-1:0]  out_travel_time;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  int mismatches;
  int pending_results;

  int unsigned      burst_left;
  int unsigned      est_pos;
  logic [CFG_W-1:0] stroke_now;
  int unsigned      quiet_cycles;
  int unsigned      rx_cyc;
  int unsigned      rx_mode;
  int unsigned      hold_left;
  int unsigned      holds_taken;
  int unsigned      hold_reqs;
  int unsigned      chk_sent;
  logic [CFG_W-1:0] phase_strokes [8];

  timed_valve_position_tracker_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_moving     (out_moving),
    .out_opening    (out_opening),
    .out_done_res   (out_done_res),
    .out_travel_time(out_travel_time),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  tvpt_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_moving     (out_moving),
    .out_opening    (out_opening),
    .out_done_res   (out_done_res),
    .out_travel_time(out_travel_time),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending_results(pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: own stall pattern, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left == 0 && holds_taken < hold_reqs) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= (rx_cyc % 4) != 3;
        2:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one request in bursts with random gaps; return once it is accepted.
  task automatic send(input cmd_t cmd, input int unsigned tgt);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_target <= tgt[POS_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_stroke(input logic [CFG_W-1:0] value);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    stroke_now = value;
  endtask

  // Mostly well-formed travels: a move, then ticks that finish it, or a
  // partial run cut short by a stop or by the next move; a little noise.
  task automatic run_travels(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned tgt;
    int unsigned tgt_sat;
    int unsigned cap;
    int unsigned dlt;
    int unsigned est_t;
    int unsigned n_ticks;
    int unsigned mode;
    stop_at = chk_sent + n_items;
    while (chk_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        send(cmd_t'($urandom_range(1, 3)), $urandom_range(0, 16383));
        chk_sent++;
      end else begin
        cap = (stroke_now == 0) ? 10000 : 600000 / stroke_now + 1;
        if (cap > 10000) cap = 10000;
        if ($urandom_range(0, 9) == 0) begin
          tgt = $urandom_range(0, 16383);
        end else begin
          dlt = $urandom_range(0, cap);
          if ($urandom_range(0, 1)) tgt = est_pos + dlt;
          else tgt = (est_pos > dlt) ? est_pos - dlt : 0;
          if (tgt > 16383) tgt = 16383;
        end
        send(CMD_MOVE, tgt);
        chk_sent++;
        tgt_sat = (tgt > 10000) ? 10000 : tgt;
        dlt = (tgt_sat > est_pos) ? tgt_sat - est_pos : est_pos - tgt_sat;
        est_t = dlt * stroke_now / 10000;
        est_pos = tgt_sat;
        mode = $urandom_range(0, 3);
        if (mode < 2) n_ticks = est_t + $urandom_range(0, 2);
        else n_ticks = $urandom_range(0, est_t);
        if (n_ticks > MAX_TICKS) n_ticks = MAX_TICKS;
        repeat (n_ticks) begin
          send(CMD_TICK, $urandom_range(0, 16383));
          chk_sent++;
        end
        if (mode == 2) begin
          send(CMD_STOP, $urandom_range(0, 16383));
          chk_sent++;
        end
      end
    end
  endtask

  initial begin
    phase_strokes = '{16'd37, 16'd1, 16'd250, 16'd65535, 16'd0, 16'd1200, 16'd10000, 16'd0};
    phase_strokes[7] = $urandom_range(1, 65535);
    stroke_now = STROKE_RST;
    burst_left = 0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle requests, unused code, move to the present position
    send(CMD_TICK, 0);
    send(CMD_STOP, 16383);
    send(CMD_NONE, 16383);
    send(CMD_MOVE, 0);
    // Short travel run to completion
    send(CMD_MOVE, 1);
    send(CMD_TICK, 0);
    // Move during travel: halt, then replan from the fixed position
    send(CMD_MOVE, 0);
    send(CMD_MOVE, 8);
    repeat (3) send(CMD_TICK, 8);
    send(CMD_STOP, 0);
    // Stop part way while opening
    send(CMD_MOVE, 0);
    repeat (2) send(CMD_TICK, 0);
    send(CMD_STOP, 0);
    send(CMD_MOVE, 2);
    send(CMD_STOP, 2);

    // Shortest stroke: oversized target saturates, travels of one tick at most
    write_stroke(16'd1);
    send(CMD_MOVE, 16383);
    send(CMD_MOVE, 0);
    send(CMD_TICK, 0);
    // Zero stroke: every move completes at once
    write_stroke(16'd0);
    send(CMD_MOVE, 10000);
    // Longest stroke: full travel, halted and replanned
    write_stroke(16'd65535);
    send(CMD_MOVE, 0);
    repeat (2) send(CMD_TICK, 0);
    send(CMD_MOVE, 10000);
    send(CMD_STOP, 0);
    chk_sent = 27;
    est_pos = 9999;

    foreach (phase_strokes[i]) begin
      write_stroke(phase_strokes[i]);
      // hold the results back so the block backs up onto its input
      if (i == 1 || i == 5) hold_reqs++;
      run_travels(PHASE_ITEMS);
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tvpt_pkg.sv
hdl/timed_valve_position_tracker_unit.sv
test/tvpt_checker.sv
test/tb_top.sv
